@@ rtl/pskhs_pkg.sv @@
// ----------------------------------------------------------------------------
// pskhs_pkg
// Shared types, register indexes and mapping tables for the PSK hard slicer.
// ----------------------------------------------------------------------------
package pskhs_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;
  localparam int unsigned MaxBits  = 3;
  localparam int unsigned CntW     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BITS_PER_SYMBOL = 2'd0,
    REG_GRAY_MAP        = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORDER_ZERO = 2'd0,
    ORDER_BPSK = 2'd1,
    ORDER_QPSK = 2'd2,
    ORDER_8PSK = 2'd3
  } order_e;

  // One decided symbol: bits are MSB-aligned, count is 1..3.
  typedef struct packed {
    logic [CntW-1:0]    count;
    logic [MaxBits-1:0] bits;
  } dec_t;

  function automatic logic [2:0] natural8(input logic [2:0] sym);
    logic [2:0] r;
    case (sym)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd7;
      3'd5:    r = 3'd6;
      3'd6:    r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/psk_hard_slicer_top.sv @@
// ----------------------------------------------------------------------------
// psk_hard_slicer_top
// Hard-decision BPSK/QPSK/8PSK demapper: one complex sample in, one to three
// decided bits out, MSB first, with a last flag.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------------
//   sample   | push / full       | in_phase_i[15:0], quadrature_i[15:0]
//   bit      | empty / pop       | bit_value_o, last_bit_o
//   config   | cfg_we_i          | cfg_idx_i[1:0], cfg_wdata_i[1:0]
//
// A sample is decided in the cycle it is accepted and queued (two entries).
// The serializer gives one bit per cycle while pop is high and a symbol waits,
// so a sample yields 1, 2 or 3 bits by order; the output side sets the sustained rate.
// Each side stalls on its own; full rises only when the queue holds two symbols.
// Reset: no items held, order QPSK, Gray mapping.
// ----------------------------------------------------------------------------
module psk_hard_slicer_top import pskhs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  in_phase_i,
  input  logic signed [15:0]  quadrature_i,
  output logic                empty,
  input  logic                pop,
  output logic                bit_value_o,
  output logic                last_bit_o
);

  dec_t dec_in, dec_out;
  logic dec_empty, dec_pop;

  pskhs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_phase_i   (in_phase_i),
    .quadrature_i (quadrature_i),
    .dec_o        (dec_in)
  );

  pskhs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (dec_in),
    .full_o  (full),
    .pop_i   (dec_pop),
    .rdata_o (dec_out),
    .empty_o (dec_empty)
  );

  pskhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_i       (dec_out),
    .dec_empty_i (dec_empty),
    .dec_pop_o   (dec_pop),
    .bit_value_o (bit_value_o),
    .last_bit_o  (last_bit_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

@@ rtl/pskhs_front.sv @@
// ----------------------------------------------------------------------------
// pskhs_front
// Configuration registers and symbol decision: one sample in, one decided
// symbol (bit count and MSB-aligned bits) out per cycle.
// ----------------------------------------------------------------------------
module pskhs_front import pskhs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [15:0]  in_phase_i,
  input  logic signed [15:0]  quadrature_i,
  output dec_t                dec_o
);

  order_e order_q, order_d;
  logic   gray_q, gray_d;

  always_comb begin
    order_d = order_q;
    gray_d  = gray_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BITS_PER_SYMBOL: order_d = order_e'(cfg_wdata_i[1:0]);
        REG_GRAY_MAP:        gray_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_QPSK;
      gray_q  <= 1'b1;
    end else begin
      order_q <= order_d;
      gray_q  <= gray_d;
    end
  end

  logic signed [16:0] i_ext, q_ext, diff, sum;
  logic               ineg, qneg, x_bit;
  logic [2:0]         nat;

  assign i_ext = {in_phase_i[15], in_phase_i};
  assign q_ext = {quadrature_i[15], quadrature_i};
  assign diff  = q_ext - i_ext;
  assign sum   = q_ext + i_ext;
  assign ineg  = in_phase_i[15];
  assign qneg  = quadrature_i[15];
  // x_bit is set when diff and sum share a sign, i.e. when |Q| exceeds |I|
  assign x_bit = ~(diff[16] ^ sum[16]);
  assign nat   = natural8({qneg, ineg, x_bit});

  always_comb begin
    dec_o = '0;
    unique case (order_q)
      ORDER_QPSK: begin
        dec_o.count = 2'd2;
        if (!gray_q && !qneg) dec_o.bits = {1'b1, ineg, 1'b0};
        else                  dec_o.bits = {~qneg, ~ineg, 1'b0};
      end
      ORDER_8PSK: begin
        dec_o.count = 2'd3;
        if (gray_q) dec_o.bits = {qneg, ineg, x_bit};
        else        dec_o.bits = nat;
      end
      default: begin
        dec_o.count = 2'd1;
        dec_o.bits  = {~ineg, 2'b00};
      end
    endcase
  end

endmodule

@@ rtl/pskhs_fifo.sv @@
// ----------------------------------------------------------------------------
// pskhs_fifo
// Two-entry queue of decided symbols between the front and the back.
// ----------------------------------------------------------------------------
module pskhs_fifo import pskhs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  dec_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output dec_t rdata_o,
  output logic empty_o
);

  dec_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop)      cnt_d = cnt_q + 2'd1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("fifo count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wptr_q == rptr_q)
    else $error("fifo pointers disagree with count");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o && !pop_i) |=> full_o)
    else $error("fifo left full state without pop");

endmodule

@@ rtl/pskhs_back.sv @@
// ----------------------------------------------------------------------------
// pskhs_back
// Serializer: holds one symbol and hands its bits out MSB first, one per pop,
// flagging the final bit.
// ----------------------------------------------------------------------------
module pskhs_back import pskhs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  dec_t dec_i,
  input  logic dec_empty_i,
  output logic dec_pop_o,
  output logic bit_value_o,
  output logic last_bit_o,
  output logic empty,
  input  logic pop
);

  logic [MaxBits-1:0] sh_q, sh_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic               valid_q, valid_d;
  logic               take;

  assign empty       = !valid_q;
  assign bit_value_o = sh_q[MaxBits-1];
  assign last_bit_o  = (rem_q == 2'd1);
  assign take        = !valid_q || (pop && last_bit_o);
  assign dec_pop_o   = take && !dec_empty_i;

  always_comb begin
    sh_d    = sh_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    if (take) begin
      valid_d = !dec_empty_i;
      sh_d    = dec_i.bits;
      rem_d   = dec_empty_i ? 2'd0 : dec_i.count;
    end else if (pop) begin
      sh_d  = {sh_q[MaxBits-2:0], 1'b0};
      rem_d = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  a_valid_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == (rem_q != 2'd0)) else $error("valid and remaining count disagree");
  a_mid_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && valid_q && !last_bit_o) |=> valid_q)
    else $error("symbol dropped before its last bit");
  a_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && valid_q && !last_bit_o) |=> rem_q == $past(rem_q) - 2'd1)
    else $error("remaining count did not step down");

endmodule
